// File: hw/rtl/ray_circle_hit_test_unit_macros.svh
// Assertion macros for the ray/circle hit test unit.
// Expect signals clk and rst in the scope of use; no other dependencies.
`ifndef RAY_CIRCLE_HIT_TEST_UNIT_MACROS_SVH
`define RAY_CIRCLE_HIT_TEST_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RCHIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define RCHIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/rchit_pkg.sv
// Shared constants for the ray/circle hit test unit.
// No dependencies.
`default_nettype none
package rchit_pkg;
  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int RAD_W      = 16;
  localparam int WL_W       = 15;
  localparam int LQ2_W      = 2 * (WL_W + 8);
  localparam int DIST_W     = 49;
  localparam int HALF_W     = 26;
  localparam int MUL_W      = 2 * HALF_W;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int WIDE_W     = PROD_W + MUL_W + 4;
  localparam int STAGES     = 10;
  localparam logic [WL_W-1:0] WL_RESET = 15'd1024;
endpackage
`default_nettype wire

// File: hw/rtl/rchit_if.sv
// Valid/ready channel interfaces of the ray/circle hit test unit.
// Depends on rchit_pkg.
`default_nettype none
interface rchit_item_if import rchit_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] circle_x;
  logic signed [COORD_BITS-1:0] circle_y;
  logic        [RAD_W-1:0]      circle_radius;
  modport source (output valid, start_x, start_y, end_x, end_y, circle_x, circle_y,
                  circle_radius, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, circle_x, circle_y,
                circle_radius, output ready);
endinterface

interface rchit_result_if import rchit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DIST_W-1:0] centre_dist_sq;
  modport source (output valid, hit, centre_dist_sq, input ready);
  modport sink (input valid, hit, centre_dist_sq, output ready);
endinterface

interface rchit_cfg_if import rchit_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [WL_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rchit_mul.sv
// Two-stage unsigned multiplier built from four registered half-width products.
// Depends on rchit_pkg.
`default_nettype none
module rchit_mul import rchit_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [MUL_W-1:0]  a,
  input  wire logic [MUL_W-1:0]  b,
  output logic      [PROD_W-1:0] p
);
  logic [MUL_W-1:0]  pll, plh, phl, phh;
  logic [PROD_W-1:0] mid;

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= a[HALF_W-1:0] * b[HALF_W-1:0];
      plh <= a[HALF_W-1:0] * b[MUL_W-1:HALF_W];
      phl <= a[MUL_W-1:HALF_W] * b[HALF_W-1:0];
      phh <= a[MUL_W-1:HALF_W] * b[MUL_W-1:HALF_W];
    end
  end

  assign mid = ({{MUL_W{1'b0}}, plh} + {{MUL_W{1'b0}}, phl}) << HALF_W;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= {phh, pll} + mid;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/ray_circle_hit_test_unit.sv
// Throughput: one item per cycle while the skid entry is empty; ten register
// stages with wide products split over two-stage multipliers, followed by an
// output register and skid.
// Input ready is the registered state of the skid entry.
// Reset (rst, synchronous): empties pipeline and output, world_length = 1024.
`default_nettype none
`include "ray_circle_hit_test_unit_macros.svh"
module ray_circle_hit_test_unit import rchit_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  rchit_cfg_if.sink     cfg,
  rchit_item_if.sink    items,
  rchit_result_if.source results
);
  logic [WL_W-1:0]   world_length;
  logic [STAGES:1]   v;
  logic              en;
  logic              skid_v, res_v;
  logic              skid_hit, res_hit;
  logic [DIST_W-1:0] skid_d, res_d;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      world_length <= WL_RESET;
    end else if (cfg.valid) begin
      world_length <= cfg.data;
    end
  end

  assign en          = !skid_v;
  assign items.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STAGES-1:1], items.valid};
    end
  end

  // stage 1: differences and magnitudes
  logic signed [DIFF_W-1:0] ex_d, ey_d, gx_d, gy_d;
  logic [DIFF_W-1:0] exm, eym, gxm, gym;
  logic              nx1, ny1;
  logic [RAD_W-1:0]  r1;
  logic [WL_W-1:0]   wl1;

  assign ex_d = {items.end_x[COORD_BITS-1], items.end_x}
              - {items.start_x[COORD_BITS-1], items.start_x};
  assign ey_d = {items.end_y[COORD_BITS-1], items.end_y}
              - {items.start_y[COORD_BITS-1], items.start_y};
  assign gx_d = {items.circle_x[COORD_BITS-1], items.circle_x}
              - {items.start_x[COORD_BITS-1], items.start_x};
  assign gy_d = {items.circle_y[COORD_BITS-1], items.circle_y}
              - {items.start_y[COORD_BITS-1], items.start_y};

  always_ff @(posedge clk) begin
    if (en) begin
      exm <= ex_d[DIFF_W-1] ? DIFF_W'(-ex_d) : DIFF_W'(ex_d);
      eym <= ey_d[DIFF_W-1] ? DIFF_W'(-ey_d) : DIFF_W'(ey_d);
      gxm <= gx_d[DIFF_W-1] ? DIFF_W'(-gx_d) : DIFF_W'(gx_d);
      gym <= gy_d[DIFF_W-1] ? DIFF_W'(-gy_d) : DIFF_W'(gy_d);
      nx1 <= gx_d[DIFF_W-1] ^ ex_d[DIFF_W-1];
      ny1 <= gy_d[DIFF_W-1] ^ ey_d[DIFF_W-1];
      r1  <= items.circle_radius;
      wl1 <= world_length;
    end
  end

  // stage 2: squares and dot-product terms
  logic [SQ_W-1:0]    gx2, gy2, ex2, ey2, mx2, my2;
  logic [2*RAD_W-1:0] rr2;
  logic [LQ2_W-1:0]   lq2_2;
  logic               nx2, ny2;

  always_ff @(posedge clk) begin
    if (en) begin
      gx2   <= gxm * gxm;
      gy2   <= gym * gym;
      ex2   <= exm * exm;
      ey2   <= eym * eym;
      mx2   <= gxm * exm;
      my2   <= gym * eym;
      rr2   <= r1 * r1;
      lq2_2 <= {(2*WL_W)'(wl1) * (2*WL_W)'(wl1), 16'b0};
      nx2   <= nx1;
      ny2   <= ny1;
    end
  end

  // stage 3: distance, direction length, signed projection
  logic [SQ_W-1:0]    dist2_3, m2_3, pm3;
  logic               pneg3;
  logic [2*RAD_W-1:0] rr3;
  logic [LQ2_W-1:0]   lq2_3;

  always_ff @(posedge clk) begin
    if (en) begin
      dist2_3 <= gx2 + gy2;
      m2_3    <= ex2 + ey2;
      if (nx2 == ny2) begin
        pm3   <= mx2 + my2;
        pneg3 <= nx2;
      end else if (mx2 >= my2) begin
        pm3   <= mx2 - my2;
        pneg3 <= nx2;
      end else begin
        pm3   <= my2 - mx2;
        pneg3 <= ny2;
      end
      rr3   <= rr2;
      lq2_3 <= lq2_2;
    end
  end

  // stage 4: saturated distance, c, x and the gating flags
  logic [SQ_W-1:0]   m2_4, pm4, c4;
  logic [SQ_W:0]     x4;
  logic [LQ2_W-1:0]  lq2_4;
  logic [DIST_W-1:0] d4;
  logic              ok4;

  always_ff @(posedge clk) begin
    if (en) begin
      d4    <= dist2_3[SQ_W-1] ? {DIST_W{1'b1}} : dist2_3[DIST_W-1:0];
      c4    <= dist2_3 - SQ_W'(rr3);
      x4    <= {1'b0, dist2_3} - (SQ_W+1)'(rr3) + (SQ_W+1)'(lq2_3);
      ok4   <= (m2_3 != '0) && (lq2_3 != '0) && (dist2_3 >= SQ_W'(rr3))
               && !(pneg3 && (pm3 != '0));
      m2_4  <= m2_3;
      pm4   <= pm3;
      lq2_4 <= lq2_3;
    end
  end

  // stages 5-6: p^2, c*m2, m2*lq^2, x^2
  logic [PROD_W-1:0] p2_6, cm2_6, m2lq2_6, x2_6;

  rchit_mul u_mul_p2 (.clk, .en, .a(MUL_W'(pm4)), .b(MUL_W'(pm4)), .p(p2_6));
  rchit_mul u_mul_cm2 (.clk, .en, .a(MUL_W'(c4)), .b(MUL_W'(m2_4)), .p(cm2_6));
  rchit_mul u_mul_near (.clk, .en, .a(MUL_W'(m2_4)), .b(MUL_W'(lq2_4)), .p(m2lq2_6));
  rchit_mul u_mul_x2 (.clk, .en, .a(MUL_W'(x4)), .b(MUL_W'(x4)), .p(x2_6));

  logic [SQ_W-1:0]   m2_5, m2_6;
  logic [LQ2_W-1:0]  lq2_5, lq2_6;
  logic [DIST_W-1:0] d5, d6, d7, d8, d9, d10;
  logic              ok5, ok6, ok7, ok8, ok9;
  logic              quad7, quad8, quad9, near7, near8, near9;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_5  <= m2_4;
      m2_6  <= m2_5;
      lq2_5 <= lq2_4;
      lq2_6 <= lq2_5;
      d5    <= d4;
      d6    <= d5;
      d7    <= d6;
      d8    <= d7;
      d9    <= d8;
      d10   <= d9;
      ok5   <= ok4;
      ok6   <= ok5;
      ok7   <= ok6;
      ok8   <= ok7;
      ok9   <= ok8;
      quad7 <= p2_6 >= cm2_6;
      near7 <= p2_6 <= m2lq2_6;
      quad8 <= quad7;
      quad9 <= quad8;
      near8 <= near7;
      near9 <= near8;
    end
  end

  // stages 7-8: m2*x^2 and p^2*lq^2, each split into two halves
  logic [PROD_W-1:0] fl_lo, fl_hi, fr_lo, fr_hi;

  rchit_mul u_mul_fl_lo (.clk, .en, .a(MUL_W'(m2_6)), .b(x2_6[MUL_W-1:0]), .p(fl_lo));
  rchit_mul u_mul_fl_hi (.clk, .en, .a(MUL_W'(m2_6)), .b(x2_6[PROD_W-1:MUL_W]),
                         .p(fl_hi));
  rchit_mul u_mul_fr_lo (.clk, .en, .a(p2_6[MUL_W-1:0]), .b(MUL_W'(lq2_6)), .p(fr_lo));
  rchit_mul u_mul_fr_hi (.clk, .en, .a(p2_6[PROD_W-1:MUL_W]), .b(MUL_W'(lq2_6)),
                         .p(fr_hi));

  // stage 9: recombine halves; stage 10: far test and hit
  logic [WIDE_W-1:0] lhs9, rhs9;
  logic              hit10;

  always_ff @(posedge clk) begin
    if (en) begin
      lhs9  <= (WIDE_W'(fl_hi) << MUL_W) + WIDE_W'(fl_lo);
      rhs9  <= ((WIDE_W'(fr_hi) << MUL_W) + WIDE_W'(fr_lo)) << 2;
      hit10 <= ok9 && quad9 && (near9 || (lhs9 <= rhs9));
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!res_v || results.ready) begin
      if (skid_v) begin
        res_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        res_v <= v[STAGES];
      end
    end else if (v[STAGES] && !skid_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_v || results.ready) begin
      if (skid_v) begin
        res_hit <= skid_hit;
        res_d   <= skid_d;
      end else begin
        res_hit <= hit10;
        res_d   <= d10;
      end
    end else if (!skid_v) begin
      skid_hit <= hit10;
      skid_d   <= d10;
    end
  end

  assign results.valid          = res_v;
  assign results.hit            = res_hit;
  assign results.centre_dist_sq = res_d;

  `RCHIT_ASSERT_NOW(a_skid_behind_out, skid_v, res_v, "skid holds data with output empty")
  `RCHIT_ASSERT_NOW(a_skid_on_stall, $rose(skid_v), $past(res_v && !results.ready), "skid filled without stall")
  `RCHIT_ASSERT_NEXT(a_zero_dir_no_ok, en && v[3] && (m2_3 == '0), !ok4, "zero direction passed gating")
endmodule
`default_nettype wire
